// File: hw/rtl/lra_pkg.sv
`timescale 1ns / 1ps

package lra_pkg;

  localparam int NUM_LEDS      = 8;
  localparam int RING_W        = $clog2(NUM_LEDS);
  localparam int LED_IDX_W     = 3;
  localparam int COLOUR_W      = 8;
  localparam int POT_W         = 10;
  localparam int TICK_W        = 8;
  localparam int ELAPSED_W     = 11;
  localparam int PAL_W         = 4;
  localparam int PAL_ENTRIES   = 12;
  localparam int PERIOD_SCALE  = 10000;
  localparam int SCALE_W       = 14;
  localparam int PROD_W        = POT_W + SCALE_W;
  localparam int PERIOD_SHIFT  = 13;
  localparam int PERIOD_MIN    = 10;
  localparam int TICK_RESET    = 16;
  localparam int TRAIL_LEN     = 4;
  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_W    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_RUN,
    MODE_SHADOW,
    MODE_FADE
  } mode_t;

  // one frame to be drawn by the back end
  typedef struct packed {
    mode_t             mode;
    logic [RING_W-1:0] pos;
    logic [PAL_W-1:0]  pal;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // palette as green, red, blue
  function automatic logic [3*COLOUR_W-1:0] palette_grb(input logic [PAL_W-1:0] idx);
    logic [3*COLOUR_W-1:0] c;
    case (idx)
      4'd0:    c = 24'h00_ff_00;
      4'd1:    c = 24'h00_ff_7f;
      4'd2:    c = 24'h00_ff_ff;
      4'd3:    c = 24'h00_7f_ff;
      4'd4:    c = 24'h00_00_ff;
      4'd5:    c = 24'h7f_00_ff;
      4'd6:    c = 24'hff_00_ff;
      4'd7:    c = 24'hff_00_7f;
      4'd8:    c = 24'hff_00_00;
      4'd9:    c = 24'hff_7f_00;
      4'd10:   c = 24'hff_ff_00;
      4'd11:   c = 24'h7f_ff_00;
      default: c = 24'h00_00_00;
    endcase
    return c;
  endfunction

  function automatic logic [COLOUR_W-1:0] trail_blue(input logic [1:0] d);
    logic [COLOUR_W-1:0] b;
    case (d)
      2'd0:    b = 8'hff;
      2'd1:    b = 8'h80;
      2'd2:    b = 8'h40;
      default: b = 8'h10;
    endcase
    return b;
  endfunction

endpackage

// File: hw/rtl/lra_front.sv
`timescale 1ns / 1ps

module lra_front
  import lra_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              button_level,
  input  logic [POT_W-1:0]  pot_sample,
  input  logic [TICK_W-1:0] tick_ms,
  output frame_t            frame
);

  logic                 prev_button;
  mode_t                anim_mode;
  logic [ELAPSED_W-1:0] elapsed_ms;
  logic [RING_W-1:0]    ring_pos;
  logic [PAL_W-1:0]     palette_idx;

  mode_t                anim_mode_next;
  logic [ELAPSED_W-1:0] elapsed_ms_next;
  logic [RING_W-1:0]    ring_pos_next;
  logic [PAL_W-1:0]     palette_idx_next;

  logic [PROD_W-1:0]    product;
  logic [ELAPSED_W-1:0] period_raw;
  logic [ELAPSED_W-1:0] period;
  logic [ELAPSED_W:0]   count;
  logic                 step;

  always_comb begin
    anim_mode_next = anim_mode;
    if (button_level && !prev_button) begin
      case (anim_mode)
        MODE_RUN:    anim_mode_next = MODE_SHADOW;
        MODE_SHADOW: anim_mode_next = MODE_FADE;
        default:     anim_mode_next = MODE_RUN;
      endcase
    end
  end

  assign product    = PROD_W'(pot_sample) * PROD_W'(PERIOD_SCALE);
  assign period_raw = product[PERIOD_SHIFT +: ELAPSED_W];
  assign period     = (period_raw < ELAPSED_W'(PERIOD_MIN)) ? ELAPSED_W'(PERIOD_MIN)
                                                             : period_raw;
  assign count      = {1'b0, elapsed_ms} + (ELAPSED_W + 1)'(tick_ms);
  assign step       = count >= {1'b0, period};

  always_comb begin
    elapsed_ms_next  = count[ELAPSED_W-1:0];
    ring_pos_next    = ring_pos;
    palette_idx_next = palette_idx;
    if (step) begin
      elapsed_ms_next  = '0;
      ring_pos_next    = (ring_pos == RING_W'(NUM_LEDS - 1)) ? '0 : ring_pos + 1'b1;
      palette_idx_next = (palette_idx == PAL_W'(PAL_ENTRIES - 1)) ? '0
                                                                  : palette_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_button <= 1'b0;
      anim_mode   <= MODE_RUN;
      elapsed_ms  <= '0;
      ring_pos    <= '0;
      palette_idx <= '0;
    end else if (accept) begin
      prev_button <= button_level;
      anim_mode   <= anim_mode_next;
      elapsed_ms  <= elapsed_ms_next;
      ring_pos    <= ring_pos_next;
      palette_idx <= palette_idx_next;
    end
  end

  assign frame.mode = anim_mode_next;
  assign frame.pos  = ring_pos_next;
  assign frame.pal  = palette_idx_next;

endmodule

// File: hw/rtl/lra_fifo.sv
`timescale 1ns / 1ps

module lra_fifo
  import lra_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_t     push_frame,
  input  logic       pop,
  output frame_t     head,
  output fifo_stat_t stat
);

  frame_t                slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] fill;

  assign stat.full  = fill == FIFO_CNT_W'(FIFO_DEPTH);
  assign stat.empty = fill == '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: hw/rtl/lra_back.sv
`timescale 1ns / 1ps

module lra_back
  import lra_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  frame_t               head,
  input  fifo_stat_t           stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LED_IDX_W-1:0] led_index,
  output logic [COLOUR_W-1:0]  green,
  output logic [COLOUR_W-1:0]  red,
  output logic [COLOUR_W-1:0]  blue,
  output logic                 last_led
);

  frame_t              cur;
  logic                cur_valid;
  logic [RING_W-1:0]   cnt;
  logic                advance;
  logic                is_last;
  logic [RING_W:0]     diff;
  logic [RING_W:0]     behind;
  logic [3*COLOUR_W-1:0] pal_colour;
  logic [COLOUR_W-1:0] g_next;
  logic [COLOUR_W-1:0] r_next;
  logic [COLOUR_W-1:0] b_next;

  assign advance = !out_valid || !out_stall;
  assign is_last = cnt == RING_W'(NUM_LEDS - 1);
  assign pop     = advance && (!cur_valid || is_last) && !stat.empty;

  // distance behind the head of the trail, with wrap
  assign diff    = {1'b0, cur.pos} - {1'b0, cnt};
  assign behind  = diff[RING_W] ? diff + (RING_W + 1)'(NUM_LEDS) : diff;
  assign pal_colour = palette_grb(cur.pal);

  always_comb begin
    g_next = '0;
    r_next = '0;
    b_next = '0;
    case (cur.mode)
      MODE_RUN: begin
        if (cnt == cur.pos) r_next = 8'hff;
      end
      MODE_SHADOW: begin
        if (behind < (RING_W + 1)'(TRAIL_LEN)) b_next = trail_blue(behind[1:0]);
      end
      MODE_FADE: begin
        {g_next, r_next, b_next} = pal_colour;
      end
      default: begin
        g_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else if (advance) begin
      out_valid <= cur_valid;
      if (!cur_valid || is_last) begin
        cur_valid <= !stat.empty;
        cnt       <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (advance && cur_valid) begin
      led_index <= LED_IDX_W'(cnt);
      green     <= g_next;
      red       <= r_next;
      blue      <= b_next;
      last_led  <= is_last;
    end
  end

endmodule

// File: hw/rtl/led_ring_animation_engine_core.sv
// led ring animation engine: one tick word in, NUM_LEDS colour words out
// a tick's frame goes through the queue and the back end's frame register to the output register
// the back end emits one colour word a cycle while out_stall is low, NUM_LEDS words per tick
// a two-frame queue lets the front take ticks while the back end is still drawing
// reset (rst, synchronous, active high) clears mode, counters, queue and out_valid; tick_ms to 16
`timescale 1ns / 1ps

module led_ring_animation_engine_core
  import lra_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration write: tick_ms
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TICK_W-1:0]    cfg_data,
  // tick words
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 button_level,
  input  logic [POT_W-1:0]     pot_sample,
  // colour words
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LED_IDX_W-1:0] led_index,
  output logic [COLOUR_W-1:0]  green,
  output logic [COLOUR_W-1:0]  red,
  output logic [COLOUR_W-1:0]  blue,
  output logic                 last_led
);

  logic [TICK_W-1:0] tick_ms;
  logic              accept;
  logic              pop;
  frame_t            frame;
  frame_t            head;
  fifo_stat_t        stat;

  // config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_ms <= TICK_W'(TICK_RESET);
    end else if (cfg_valid && cfg_ready) begin
      tick_ms <= cfg_data;
    end
  end

  // front stalls only when the frame queue is full
  assign in_stall = stat.full;
  assign accept   = in_valid && !in_stall;

  // front: button edge, period compare, ring and palette stepping
  lra_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .button_level (button_level),
    .pot_sample   (pot_sample),
    .tick_ms      (tick_ms),
    .frame        (frame)
  );

  // frame queue between front and back
  lra_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_frame (frame),
    .pop        (pop),
    .head       (head),
    .stat       (stat)
  );

  // back: walks the ring and draws one led a cycle into the output register while out_stall is low
  lra_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .led_index (led_index),
    .green     (green),
    .red       (red),
    .blue      (blue),
    .last_led  (last_led)
  );

  // within a frame the words follow with no gap and consecutive indices
  a_frame_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_led |=>
      out_valid && led_index == LED_IDX_W'($past(led_index) + 1'b1))
    else $error("colour words of a frame not consecutive");

  // the closing word of a frame carries the final led number
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_led |-> led_index == LED_IDX_W'(NUM_LEDS - 1))
    else $error("last_led on wrong led");

  // queue never overflows nor underflows
  a_queue: assert property (@(posedge clk) disable iff (rst)
    !(accept && stat.full) && !(pop && stat.empty))
    else $error("frame queue overrun");

endmodule

// File: verif/lra_checker.sv
`timescale 1ns / 1ps

module lra_checker
  import lra_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [TICK_W-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 button_level,
  input  logic [POT_W-1:0]     pot_sample,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [LED_IDX_W-1:0] led_index,
  input  logic [COLOUR_W-1:0]  green,
  input  logic [COLOUR_W-1:0]  red,
  input  logic [COLOUR_W-1:0]  blue,
  input  logic                 last_led,
  output int                   fails,
  output int                   pending,
  output int                   words_checked
);

  typedef struct packed {
    logic [LED_IDX_W-1:0] idx;
    logic [COLOUR_W-1:0]  g;
    logic [COLOUR_W-1:0]  r;
    logic [COLOUR_W-1:0]  b;
    logic                 last;
  } colour_word_t;

  colour_word_t         colours_due[$];
  logic [TICK_W-1:0]    tick_ms;
  logic                 prev_button;
  mode_t                mode;
  logic [ELAPSED_W-1:0] elapsed_ms;
  logic [RING_W-1:0]    ring_pos;
  logic [PAL_W-1:0]     pal_idx;
  int                   n_fail;
  int                   n_checked;

  // fade palette, green then red then blue
  function automatic logic [3*COLOUR_W-1:0] fade_grb(input logic [PAL_W-1:0] idx);
    logic [3*COLOUR_W-1:0] c;
    case (idx)
      0:       c = {8'h00, 8'hff, 8'h00};
      1:       c = {8'h00, 8'hff, 8'h7f};
      2:       c = {8'h00, 8'hff, 8'hff};
      3:       c = {8'h00, 8'h7f, 8'hff};
      4:       c = {8'h00, 8'h00, 8'hff};
      5:       c = {8'h7f, 8'h00, 8'hff};
      6:       c = {8'hff, 8'h00, 8'hff};
      7:       c = {8'hff, 8'h00, 8'h7f};
      8:       c = {8'hff, 8'h00, 8'h00};
      9:       c = {8'hff, 8'h7f, 8'h00};
      10:      c = {8'hff, 8'hff, 8'h00};
      11:      c = {8'h7f, 8'hff, 8'h00};
      default: c = '0;
    endcase
    return c;
  endfunction

  // one tick: mode step, speed counter, then a whole frame of colours
  task automatic draw_frame(input logic btn, input logic [POT_W-1:0] pot);
    int           period;
    int           count;
    int           behind;
    colour_word_t w;
    if (btn && !prev_button) begin
      case (mode)
        MODE_RUN:    mode = MODE_SHADOW;
        MODE_SHADOW: mode = MODE_FADE;
        default:     mode = MODE_RUN;
      endcase
    end
    prev_button = btn;

    period = (int'(pot) * PERIOD_SCALE) >> PERIOD_SHIFT;
    if (period < PERIOD_MIN) period = PERIOD_MIN;
    count = int'(elapsed_ms) + int'(tick_ms);
    if (count >= period) begin
      count    = 0;
      ring_pos = RING_W'((int'(ring_pos) + 1) % NUM_LEDS);
      pal_idx  = PAL_W'((int'(pal_idx) + 1) % PAL_ENTRIES);
    end
    elapsed_ms = ELAPSED_W'(count);

    for (int i = 0; i < NUM_LEDS; i++) begin
      w      = '0;
      w.idx  = LED_IDX_W'(i);
      w.last = (i == NUM_LEDS - 1);
      case (mode)
        MODE_RUN: if (i == int'(ring_pos)) w.r = 8'hff;
        MODE_SHADOW: begin
          behind = (int'(ring_pos) + NUM_LEDS - i) % NUM_LEDS;
          case (behind)
            0:       w.b = 8'hff;
            1:       w.b = 8'h80;
            2:       w.b = 8'h40;
            3:       w.b = 8'h10;
            default: w.b = 8'h00;
          endcase
        end
        MODE_FADE: {w.g, w.r, w.b} = fade_grb(pal_idx);
        default: w.g = 8'h00;
      endcase
      colours_due.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    colour_word_t want;
    if (rst) begin
      tick_ms     = TICK_W'(TICK_RESET);
      prev_button = 1'b0;
      mode        = MODE_RUN;
      elapsed_ms  = '0;
      ring_pos    = '0;
      pal_idx     = '0;
      colours_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) tick_ms = cfg_data;
      if (out_valid && !out_stall) begin
        n_checked++;
        if (colours_due.size() == 0) begin
          $display("%0t: colour word with none expected, got led %0d grb %h %h %h last %0b",
                   $time, led_index, green, red, blue, last_led);
          n_fail++;
        end else begin
          want = colours_due.pop_front();
          if (want.idx !== led_index || want.g !== green || want.r !== red ||
              want.b !== blue || want.last !== last_led) begin
            $display("%0t: colour word mismatch, expected led %0d grb %h %h %h last %0b",
                     $time, want.idx, want.g, want.r, want.b, want.last);
            $display("%0t:   actual led %0d grb %h %h %h last %0b",
                     $time, led_index, green, red, blue, last_led);
            n_fail++;
          end
        end
      end
      if (in_valid && !in_stall) draw_frame(button_level, pot_sample);
    end
    fails         <= n_fail;
    pending       <= colours_due.size();
    words_checked <= n_checked;
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import lra_pkg::*;

  // watchdog limit: longest quiet spell is the long receiver hold plus a few gaps
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_AFTER  = 400;
  localparam int HOLD_CYCLES = 120;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [TICK_W-1:0]    cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic                 button_level = 1'b0;
  logic [POT_W-1:0]     pot_sample   = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b1;
  logic [LED_IDX_W-1:0] led_index;
  logic [COLOUR_W-1:0]  green;
  logic [COLOUR_W-1:0]  red;
  logic [COLOUR_W-1:0]  blue;
  logic                 last_led;

  int fails;
  int pending;
  int words_checked;
  int ticks_sent   = 0;
  int cfg_writes   = 0;
  int quiet_cycles = 0;
  int words_taken  = 0;
  bit src_calm     = 1'b0;
  bit sink_calm    = 1'b0;
  bit held         = 1'b0;

  always #5 clk = ~clk;

  led_ring_animation_engine_core dut (.*);

  // checker sits beside the block, watching all three channels
  lra_checker frame_check (.*);

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // each side idles a random gap before each word, with calm stretches of no idling
  function automatic int pick_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  // colour word receiver, with one long hold so the frame queue fills and the input stalls
  initial begin : colour_sink
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) sink_calm = !sink_calm;
      gap = pick_gap(sink_calm);
      if (!held && words_taken >= HOLD_AFTER) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      words_taken++;
    end
  end

  // offer one tick word and hold it until taken
  task automatic send_tick(input logic btn, input logic [POT_W-1:0] pot);
    int gap;
    if ($urandom_range(0, 19) == 0) src_calm = !src_calm;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    button_level <= btn;
    pot_sample   <= pot;
    do @(posedge clk); while (!(in_valid && !in_stall));
    ticks_sent++;
  endtask

  // stop offering and wait for every expected colour word to come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // tick_ms is only rewritten with the block idle
  task automatic write_tick_ms(input logic [TICK_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // random ticks: button flips often, pot mostly small so the ring keeps moving
  task automatic random_ticks(input int count);
    logic             btn;
    logic [POT_W-1:0] pot;
    for (int n = 0; n < count; n++) begin
      btn = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0:       pot = POT_W'($urandom_range(0, 15));
        1:       pot = POT_W'($urandom_range(0, 100));
        2:       pot = POT_W'($urandom_range(0, 1023));
        default: pot = $urandom_range(0, 1) ? 10'h3ff : 10'h000;
      endcase
      send_tick(btn, pot);
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset tick_ms of 16
    send_tick(1'b0, 10'd0);     // minimum period, ring steps every tick
    send_tick(1'b0, 10'd0);
    send_tick(1'b1, 10'd0);     // rising edge: running light to shadowed light
    send_tick(1'b1, 10'd1023);  // held button, no further step; longest period
    send_tick(1'b0, 10'd1023);
    send_tick(1'b1, 10'd1023);  // into colour fade
    send_tick(1'b0, 10'd1023);
    send_tick(1'b0, 10'd1023);
    send_tick(1'b0, 10'd1023);  // count builds up well past the short periods
    send_tick(1'b0, 10'd512);
    send_tick(1'b0, 10'd5);     // period shrinks below the count, clears at once
    send_tick(1'b0, 10'd8);     // scaled period under the floor of 10
    send_tick(1'b1, 10'd8);     // mode wraps back to running light
    send_tick(1'b0, 10'd1023);
    send_tick(1'b1, 10'd0);
    send_tick(1'b0, 10'd341);
    send_tick(1'b1, 10'd1022);
    send_tick(1'b0, 10'd1);
    send_tick(1'b0, 10'd682);
    send_tick(1'b0, 10'd0);

    // largest step: the long receiver hold falls in here
    write_tick_ms(8'd255);
    random_ticks(40);

    // zero step: elapsed time stops growing, so the ring steps at most once more; the mode still moves
    write_tick_ms(8'd0);
    random_ticks(20);

    // smallest step
    write_tick_ms(8'd1);
    random_ticks(40);

    write_tick_ms(TICK_W'($urandom_range(2, 254)));
    random_ticks(60);

    settle();
    repeat (10) @(posedge clk);

    $display("run covered %0d ticks over %0d tick_ms settings beyond reset, %0d colour words",
             ticks_sent, cfg_writes, words_checked);
    if (fails == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: led_ring_animation_engine_core.f
hw/rtl/lra_pkg.sv
hw/rtl/lra_front.sv
hw/rtl/lra_fifo.sv
hw/rtl/lra_back.sv
hw/rtl/led_ring_animation_engine_core.sv
verif/lra_checker.sv
verif/tb.sv
